// ===== hw/rtl/cia_pkg.sv =====
// ----------------------------------------------------------------------------
// cia_pkg: shared types for the checked 64-bit ALU
// Operation codes, beat payloads and the word that moves along the cell chain.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned Width = 64;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_SHL = 4'd8,
    OP_SHR = 4'd9,
    OP_NEG = 4'd10,
    OP_NOT = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    K_SIMPLE = 2'd0,
    K_MUL    = 2'd1,
    K_DIV    = 2'd2,
    K_MOD    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [63:0] left_operand;
    logic signed [63:0] right_operand;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               ok;
  } out_t;

  typedef struct packed {
    kind_e       kind;
    logic        ok;
    logic        neg;
    logic        ovf;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
  } cell_t;

endpackage

// ===== hw/rtl/cia_front.sv =====
// ----------------------------------------------------------------------------
// cia_front: operand decode stage
// Finishes the operations that need no chain and prepares magnitudes for the chain.
// ----------------------------------------------------------------------------
module cia_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cia_pkg::in_t   data_i,
  output logic           valid_o,
  output cia_pkg::cell_t data_o
);

  logic signed [63:0] a, b, sum, dif, ng;
  logic [63:0]        abs_a, abs_b, shl_lim;
  logic               a_nn, b_nn, sh_ok, div_ok;
  cia_pkg::cell_t     c_d, c_q;
  logic               valid_q;

  assign a       = data_i.left_operand;
  assign b       = data_i.right_operand;
  assign sum     = a + b;
  assign dif     = a - b;
  assign ng      = -a;
  assign abs_a   = a[63] ? ng : a;
  assign abs_b   = b[63] ? -b : b;
  assign a_nn    = !a[63];
  assign b_nn    = !b[63];
  assign sh_ok   = a_nn && b_nn && (b < 64'sd63);
  assign shl_lim = 64'h7FFF_FFFF_FFFF_FFFF >> b[5:0];
  assign div_ok  = (b != 64'sd0) && !(a == {1'b1, 63'd0} && b == -64'sd1);

  always_comb begin
    c_d      = '0;
    c_d.kind = cia_pkg::K_SIMPLE;
    unique case (data_i.operation)
      cia_pkg::OP_ADD: begin
        c_d.ok = !(a[63] == b[63] && sum[63] != a[63]);
        c_d.x  = sum;
      end
      cia_pkg::OP_SUB: begin
        c_d.ok = !(a[63] != b[63] && dif[63] != a[63]);
        c_d.x  = dif;
      end
      cia_pkg::OP_MUL: begin
        c_d.kind = cia_pkg::K_MUL;
        c_d.ok   = 1'b1;
        c_d.neg  = a[63] ^ b[63];
        c_d.y    = abs_a;
        c_d.z    = abs_b;
      end
      cia_pkg::OP_DIV: begin
        c_d.kind = cia_pkg::K_DIV;
        c_d.ok   = div_ok;
        c_d.neg  = a[63] ^ b[63];
        c_d.y    = abs_b;
        c_d.z    = abs_a;
      end
      cia_pkg::OP_MOD: begin
        c_d.kind = cia_pkg::K_MOD;
        c_d.ok   = div_ok;
        c_d.neg  = a[63];
        c_d.y    = abs_b;
        c_d.z    = abs_a;
      end
      cia_pkg::OP_AND: begin
        c_d.ok = a_nn && b_nn;
        c_d.x  = a & b;
      end
      cia_pkg::OP_OR: begin
        c_d.ok = a_nn && b_nn;
        c_d.x  = a | b;
      end
      cia_pkg::OP_XOR: begin
        c_d.ok = a_nn && b_nn;
        c_d.x  = a ^ b;
      end
      cia_pkg::OP_SHL: begin
        c_d.ok = sh_ok && (a <= shl_lim);
        c_d.x  = a << b[5:0];
      end
      cia_pkg::OP_SHR: begin
        c_d.ok = sh_ok;
        c_d.x  = a >> b[5:0];
      end
      cia_pkg::OP_NEG: begin
        c_d.ok = (a != {1'b1, 63'd0});
        c_d.x  = ng;
      end
      cia_pkg::OP_NOT: begin
        c_d.ok = 1'b1;
        c_d.x  = ~a;
      end
      default: begin
        c_d.ok = 1'b0;
      end
    endcase
    if (!c_d.ok && c_d.kind == cia_pkg::K_SIMPLE) begin
      c_d.x = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = c_q;

endmodule

// ===== hw/rtl/cia_cell.sv =====
// ----------------------------------------------------------------------------
// cia_cell: one step of shift-add multiply or restoring divide
// Consumes one bit of the multiplier or dividend and passes the word on.
// ----------------------------------------------------------------------------
module cia_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cia_pkg::cell_t data_i,
  output logic           valid_o,
  output cia_pkg::cell_t data_o
);

  cia_pkg::cell_t c_d, c_q;
  logic           valid_q;
  logic [64:0]    acc, rem, sub;

  assign acc = {1'b0, data_i.x[62:0], 1'b0} + {1'b0, (data_i.z[63] ? data_i.y : 64'd0)};
  assign rem = {data_i.x, data_i.z[63]};
  assign sub = rem - {1'b0, data_i.y};

  always_comb begin
    c_d = data_i;
    case (data_i.kind) inside
      cia_pkg::K_MUL: begin
        c_d.x   = acc[63:0];
        c_d.ovf = data_i.ovf | data_i.x[63] | acc[64];
        c_d.z   = {data_i.z[62:0], 1'b0};
      end
      cia_pkg::K_DIV, cia_pkg::K_MOD: begin
        c_d.x = sub[64] ? rem[63:0] : sub[63:0];
        c_d.z = {data_i.z[62:0], !sub[64]};
      end
      default: begin
        c_d = data_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = c_q;

endmodule

// ===== hw/rtl/cia_back.sv =====
// ----------------------------------------------------------------------------
// cia_back: sign and range fix-up with the output register
// Applies the result sign, checks the signed range and zeroes failures.
// ----------------------------------------------------------------------------
module cia_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cia_pkg::cell_t data_i,
  output logic           valid_o,
  output cia_pkg::out_t  data_o
);

  logic [63:0]   mag;
  logic          fits;
  cia_pkg::out_t o_d, o_q;
  logic          valid_q;

  always_comb begin
    mag = data_i.x;
    if (data_i.kind == cia_pkg::K_DIV) begin
      mag = data_i.z;
    end
    fits = !data_i.ovf && (!mag[63] || (data_i.neg && mag[62:0] == 63'd0));
    o_d  = '0;
    if (data_i.kind == cia_pkg::K_SIMPLE) begin
      o_d.ok    = data_i.ok;
      o_d.value = data_i.x;
    end else if (data_i.ok && fits) begin
      o_d.ok    = 1'b1;
      o_d.value = data_i.neg ? -mag : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_q <= o_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = o_q;

endmodule

// ===== hw/rtl/checked_int64_alu.sv =====
// ----------------------------------------------------------------------------
// checked_int64_alu: overflow-checked signed 64-bit ALU
// Each input beat carries an operation and two operands; each output beat
// carries the exact result and an ok flag, with the value zero on failure.
//
// Both channels use valid/ready. One beat is accepted per cycle unless the
// receiver stalls. A beat passes a decode stage, a chain of 64 cells that
// each resolve one multiplier or dividend bit, and an output register, so
// results appear in the order of their input beats. All operations share
// the chain. When the receiver stalls with a result waiting, the whole chain
// holds and in_ready_o drops until the output beat is taken. Reset empties
// the chain; no result is pending afterwards.
// ----------------------------------------------------------------------------
module checked_int64_alu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cia_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cia_pkg::out_t out_data_o
);

  localparam int unsigned Cells = cia_pkg::Width;

  logic           adv;
  logic           v [Cells+1];
  cia_pkg::cell_t d [Cells+1];

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  cia_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (v[0]),
    .data_o  (d[0])
  );

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    cia_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v[i]),
      .data_i  (d[i]),
      .valid_o (v[i+1]),
      .data_o  (d[i+1])
    );
  end

  cia_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v[Cells]),
    .data_i  (d[Cells]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
